### hdl/tia_pkg.sv
package tia_pkg;

    localparam int unsigned WORD_BITS = 31;
    localparam int unsigned CNT_BITS  = $clog2(WORD_BITS);

    localparam logic [3:0] OP_ADD  = 4'd0;
    localparam logic [3:0] OP_SUB  = 4'd1;
    localparam logic [3:0] OP_MUL  = 4'd2;
    localparam logic [3:0] OP_IDIV = 4'd3;
    localparam logic [3:0] OP_AND  = 4'd4;
    localparam logic [3:0] OP_OR   = 4'd5;
    localparam logic [3:0] OP_SHL  = 4'd6;
    localparam logic [3:0] OP_SHR  = 4'd7;
    localparam logic [3:0] OP_REM  = 4'd8;
    localparam logic [3:0] OP_MOD  = 4'd9;
    localparam logic [3:0] OP_NEG  = 4'd10;
    localparam logic [3:0] OP_NOT  = 4'd11;
    localparam logic [3:0] OP_ABS  = 4'd12;
    localparam logic [3:0] OP_SIGN = 4'd13;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OVF  = 2'd1;
    localparam logic [1:0] ST_ZDIV = 2'd2;

    typedef logic signed [WORD_BITS-1:0] t_word;
    typedef logic signed [WORD_BITS:0]   t_wide;
    typedef logic [WORD_BITS-1:0]        t_mag;

    // Side information that rides along the divider stages.
    typedef struct packed {
        logic [3:0] op;
        logic       sa;
        logic       sb;
        t_word      b;
        t_word      r;
        logic [1:0] st;
    } t_tag;

    // Restoring divider state: partial remainder, dividend/quotient shifter, divisor.
    typedef struct packed {
        t_mag rem;
        t_mag dq;
        t_mag d;
    } t_div;

endpackage

### hdl/tia_front.sv
module tia_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [3:0]        i_op,
    input  tia_pkg::t_word    i_a,
    input  tia_pkg::t_word    i_b,
    output logic              o_valid,
    output tia_pkg::t_tag     o_tag,
    output tia_pkg::t_div     o_div
);

    localparam int unsigned W  = tia_pkg::WORD_BITS;
    localparam int unsigned PW = 2 * W;
    localparam logic [PW-1:0] LIM_POS = (PW'(1) << (W - 1)) - PW'(1);
    localparam logic [PW-1:0] LIM_NEG = PW'(1) << (W - 1);

    // stage 1: input register
    logic                 r1_v;
    logic [3:0]           r1_op;
    tia_pkg::t_word       r1_a;
    tia_pkg::t_word       r1_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
        end
        if (i_en) begin
            r1_op <= i_op;
            r1_a  <= i_a;
            r1_b  <= i_b;
        end
    end

    // stage 2: magnitudes and the operations that need no product or division
    logic                        sa;
    logic                        sb;
    tia_pkg::t_mag               ma;
    tia_pkg::t_mag               mb;
    logic [tia_pkg::CNT_BITS-1:0] cnt;
    tia_pkg::t_word              shl_v;
    tia_pkg::t_word              shr_v;
    tia_pkg::t_wide              wa;
    tia_pkg::t_wide              wb;
    tia_pkg::t_wide              wr;
    logic                        chk;
    logic                        ovf2;

    always_comb begin
        sa = r1_a[W-1];
        sb = r1_b[W-1];
        ma = sa ? tia_pkg::t_mag'(-r1_a) : tia_pkg::t_mag'(r1_a);
        mb = sb ? tia_pkg::t_mag'(-r1_b) : tia_pkg::t_mag'(r1_b);
        if (sb) begin
            cnt = '0;
        end else if (r1_b > tia_pkg::t_word'(W - 1)) begin
            cnt = tia_pkg::CNT_BITS'(W - 1);
        end else begin
            cnt = r1_b[tia_pkg::CNT_BITS-1:0];
        end
        shl_v = r1_a << cnt;
        shr_v = r1_a >>> cnt;
        wa    = {r1_a[W-1], r1_a};
        wb    = {r1_b[W-1], r1_b};
        chk   = 1'b1;
        case (r1_op)
            tia_pkg::OP_ADD:  wr = wa + wb;
            tia_pkg::OP_SUB:  wr = wa - wb;
            tia_pkg::OP_AND:  wr = wa & wb;
            tia_pkg::OP_OR:   wr = wa | wb;
            tia_pkg::OP_SHL:  wr = {shl_v[W-1], shl_v};
            tia_pkg::OP_SHR:  wr = {shr_v[W-1], shr_v};
            tia_pkg::OP_NEG:  wr = -wa;
            tia_pkg::OP_NOT:  wr = ~wa;
            tia_pkg::OP_ABS:  wr = sa ? -wa : wa;
            tia_pkg::OP_SIGN: begin
                if (sa) begin
                    wr = {(W+1){1'b1}};
                end else begin
                    wr = (r1_a != '0) ? tia_pkg::t_wide'(1) : '0;
                end
            end
            default: begin
                wr  = '0;
                chk = 1'b0;
            end
        endcase
        ovf2 = chk && (wr[W] != wr[W-1]);
    end

    logic                 r2_v;
    logic [3:0]           r2_op;
    logic                 r2_sa;
    logic                 r2_sb;
    tia_pkg::t_word       r2_b;
    tia_pkg::t_mag        r2_ma;
    tia_pkg::t_mag        r2_mb;
    tia_pkg::t_word       r2_r;
    logic [1:0]           r2_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (i_en) begin
            r2_v <= r1_v;
        end
        if (i_en) begin
            r2_op <= r1_op;
            r2_sa <= sa;
            r2_sb <= sb;
            r2_b  <= r1_b;
            r2_ma <= ma;
            r2_mb <= mb;
            r2_r  <= ovf2 ? '0 : wr[W-1:0];
            r2_st <= ovf2 ? tia_pkg::ST_OVF : tia_pkg::ST_OK;
        end
    end

    // stage 3: magnitude product
    logic                 r3_v;
    logic [PW-1:0]        r3_p;
    tia_pkg::t_tag        r3_tag;
    tia_pkg::t_div        r3_div;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (i_en) begin
            r3_v <= r2_v;
        end
        if (i_en) begin
            r3_p       <= PW'(r2_ma) * PW'(r2_mb);
            r3_tag.op  <= r2_op;
            r3_tag.sa  <= r2_sa;
            r3_tag.sb  <= r2_sb;
            r3_tag.b   <= r2_b;
            r3_tag.r   <= r2_r;
            r3_tag.st  <= r2_st;
            r3_div.rem <= '0;
            r3_div.dq  <= r2_ma;
            r3_div.d   <= r2_mb;
        end
    end

    // stage 4: signed product and range check
    logic                 mneg;
    logic                 movf;
    tia_pkg::t_tag        tag4;

    always_comb begin
        mneg = r3_tag.sa ^ r3_tag.sb;
        movf = r3_p > (mneg ? LIM_NEG : LIM_POS);
        tag4 = r3_tag;
        if (r3_tag.op == tia_pkg::OP_MUL) begin
            tag4.st = movf ? tia_pkg::ST_OVF : tia_pkg::ST_OK;
            if (movf) begin
                tag4.r = '0;
            end else if (mneg) begin
                tag4.r = -tia_pkg::t_word'(r3_p[W-1:0]);
            end else begin
                tag4.r = tia_pkg::t_word'(r3_p[W-1:0]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r3_v;
        end
        if (i_en) begin
            o_tag <= tag4;
            o_div <= r3_div;
        end
    end

endmodule

### hdl/tia_div.sv
module tia_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  tia_pkg::t_tag     i_tag,
    input  tia_pkg::t_div     i_div,
    output logic              o_valid,
    output tia_pkg::t_tag     o_tag,
    output tia_pkg::t_div     o_div
);

    localparam int unsigned W = tia_pkg::WORD_BITS;

    logic              r_v   [W];
    tia_pkg::t_tag     r_tag [W];
    tia_pkg::t_div     r_dv  [W];

    // one quotient bit per stage, most significant first
    for (genvar k = 0; k < W; k++) begin : g_stage
        logic              pv;
        tia_pkg::t_tag     ptag;
        tia_pkg::t_div     prev;
        tia_pkg::t_div     n_dv;
        logic [W:0]        t;
        logic [W:0]        diff;
        logic              ge;

        if (k == 0) begin : g_first
            assign pv   = i_valid;
            assign ptag = i_tag;
            assign prev = i_div;
        end else begin : g_next
            assign pv   = r_v[k-1];
            assign ptag = r_tag[k-1];
            assign prev = r_dv[k-1];
        end

        always_comb begin
            t         = {prev.rem, prev.dq[W-1]};
            diff      = t - {1'b0, prev.d};
            ge        = t >= {1'b0, prev.d};
            n_dv.rem  = ge ? diff[W-1:0] : t[W-1:0];
            n_dv.dq   = {prev.dq[W-2:0], ge};
            n_dv.d    = prev.d;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= pv;
            end
            if (i_en) begin
                r_tag[k] <= ptag;
                r_dv[k]  <= n_dv;
            end
        end
    end

    assign o_valid = r_v[W-1];
    assign o_tag   = r_tag[W-1];
    assign o_div   = r_dv[W-1];

endmodule

### hdl/tia_back.sv
module tia_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  tia_pkg::t_tag     i_tag,
    input  tia_pkg::t_div     i_div,
    output logic              o_valid,
    output tia_pkg::t_word    o_result,
    output logic [1:0]        o_status
);

    localparam int unsigned W = tia_pkg::WORD_BITS;

    tia_pkg::t_wide    qw;
    tia_pkg::t_word    rr;
    tia_pkg::t_word    res;
    logic [1:0]        st;
    logic              zdiv;

    always_comb begin
        qw   = {1'b0, i_div.dq};
        if (i_tag.sa ^ i_tag.sb) begin
            qw = -qw;
        end
        rr   = i_tag.sa ? -tia_pkg::t_word'(i_div.rem) : tia_pkg::t_word'(i_div.rem);
        zdiv = (i_tag.b == '0);
        res  = i_tag.r;
        st   = i_tag.st;
        case (i_tag.op)
            tia_pkg::OP_IDIV: begin
                res = qw[W-1:0];
                st  = (qw[W] != qw[W-1]) ? tia_pkg::ST_OVF : tia_pkg::ST_OK;
            end
            tia_pkg::OP_REM: begin
                res = rr;
                st  = tia_pkg::ST_OK;
            end
            tia_pkg::OP_MOD: begin
                // floored modulo: move a nonzero remainder over to the divisor's sign
                res = (i_div.rem != '0 && (i_tag.sa != i_tag.sb)) ? rr + i_tag.b : rr;
                st  = tia_pkg::ST_OK;
            end
            default: begin
                res = i_tag.r;
                st  = i_tag.st;
            end
        endcase
        if ((i_tag.op == tia_pkg::OP_IDIV || i_tag.op == tia_pkg::OP_REM ||
             i_tag.op == tia_pkg::OP_MOD) && zdiv) begin
            st = tia_pkg::ST_ZDIV;
        end
        if (st != tia_pkg::ST_OK) begin
            res = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
        if (i_en) begin
            o_result <= res;
            o_status <= st;
        end
    end

endmodule

### hdl/tagged_int_alu_with_overflow.sv
// Channel   Direction  tdata (low bit up)                    tuser
// s_axis    in         left_operand[30:0], right_operand     operation[3:0]
//                      [61:31], zero pad [63:62]
// m_axis    out        result[30:0], zero pad [31]           status[1:0]
//
// The pipeline has four front stages (input, add/logic/shift ops, product,
// product sign and range), 31 divider stages resolving one quotient bit each,
// and the output register. One beat is taken every cycle while m_axis is not stalled.
// Reset clears only the valid bits of every stage.
// A stall on m_axis freezes the whole pipeline; s_axis_tready drops only then.
module tagged_int_alu_with_overflow (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,  // left_operand, right_operand
    input  logic [3:0]  i_s_axis_tuser,  // operation
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,  // result
    output logic [1:0]  o_m_axis_tuser   // status
);

    localparam int unsigned W = tia_pkg::WORD_BITS;

    logic              en;
    logic              f_valid;
    tia_pkg::t_tag     f_tag;
    tia_pkg::t_div     f_div;
    logic              d_valid;
    tia_pkg::t_tag     d_tag;
    tia_pkg::t_div     d_div;
    tia_pkg::t_word    result;

    // advance everything unless a finished beat is held at the output
    assign en              = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = en;

    tia_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_s_axis_tvalid),
        .i_op    (i_s_axis_tuser),
        .i_a     (tia_pkg::t_word'(i_s_axis_tdata[W-1:0])),
        .i_b     (tia_pkg::t_word'(i_s_axis_tdata[2*W-1:W])),
        .o_valid (f_valid),
        .o_tag   (f_tag),
        .o_div   (f_div)
    );

    tia_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (f_valid),
        .i_tag   (f_tag),
        .i_div   (f_div),
        .o_valid (d_valid),
        .o_tag   (d_tag),
        .o_div   (d_div)
    );

    tia_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (d_valid),
        .i_tag    (d_tag),
        .i_div    (d_div),
        .o_valid  (o_m_axis_tvalid),
        .o_result (result),
        .o_status (o_m_axis_tuser)
    );

    assign o_m_axis_tdata = {1'b0, result};

    a_ready_follows_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready == (!o_m_axis_tvalid || i_m_axis_tready))
        else $error("input ready does not follow output stall");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser != tia_pkg::ST_OK) |-> (result == '0))
        else $error("nonzero result with error status");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tuser == tia_pkg::ST_OK ||
            o_m_axis_tuser == tia_pkg::ST_OVF || o_m_axis_tuser == tia_pkg::ST_ZDIV))
        else $error("undefined status code");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(result) && $stable(o_m_axis_tuser))
        else $error("pipeline moved during stall");

endmodule
